// File: rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and codes of the process table tracker
// Function and status codes, controller command and datapath status structs.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned IdW     = 22;
  localparam int unsigned PagesW  = 32;
  localparam int unsigned OomW    = 11;
  localparam int unsigned GenW    = 8;
  localparam int unsigned PageBW  = 17;
  localparam int unsigned MemW    = 48;
  localparam int unsigned ThrW    = 14;
  localparam int unsigned SlotW   = 8;
  localparam int unsigned CountW  = 9;
  localparam int unsigned CfgIdxW = 2;

  // Table size; slot and count widths are sized for it
  localparam int unsigned TableDepth = 256;

  localparam logic [FuncW-1:0] FuncUpdate = 3'd0;
  localparam logic [FuncW-1:0] FuncExpire = 3'd1;
  localparam logic [FuncW-1:0] FuncBegin  = 3'd2;
  localparam logic [FuncW-1:0] FuncEnd    = 3'd3;
  localparam logic [FuncW-1:0] FuncKill   = 3'd4;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusNotFound = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgPageBytes = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTotalMem  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd2;

  localparam logic [MemW-1:0] Mem48Max = {MemW{1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // latch input word, reset walk
    logic walk;      // visit current walk index
    logic finish;    // commit the operation, build result word
  } ptt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic walk_done; // walk index has reached its limit, hit found, or no walk is needed
    logic fin_done;  // arithmetic of finish step settled
  } ptt_sts_t;

  // Result word
  typedef struct packed {
    logic [1:0]        status;
    logic [SlotW-1:0]  slot;
    logic [IdW-1:0]    target_id;
    logic              over_limit;
    logic [MemW-1:0]   memory_bytes;
    logic [CountW-1:0] live_count;
    logic [CountW-1:0] removed_count;
  } ptt_res_t;

endpackage

// File: rtl/ptt_req_if.sv
// ----------------------------------------------------------------------------
// ptt_req_if / ptt_res_if: valid-ready channels of the tracker
// Request words carry one command; result words carry one response.
// ----------------------------------------------------------------------------
interface ptt_req_if;
  logic                            valid;
  logic                            ready;
  logic [ptt_pkg::FuncW-1:0]       func;
  logic [ptt_pkg::IdW-1:0]         proc_id;
  logic [ptt_pkg::PagesW-1:0]      resident_pages;
  logic [ptt_pkg::OomW-1:0]        oom_value;
  modport source (output valid, func, proc_id, resident_pages, oom_value, input ready);
  modport sink   (input valid, func, proc_id, resident_pages, oom_value, output ready);
endinterface

interface ptt_res_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [ptt_pkg::SlotW-1:0]       slot;
  logic [ptt_pkg::IdW-1:0]         target_id;
  logic                            over_limit;
  logic [ptt_pkg::MemW-1:0]        memory_bytes;
  logic [ptt_pkg::CountW-1:0]      live_count;
  logic [ptt_pkg::CountW-1:0]      removed_count;
  modport source (output valid, status, slot, target_id, over_limit, memory_bytes,
                  live_count, removed_count, input ready);
  modport sink   (input valid, status, slot, target_id, over_limit, memory_bytes,
                  live_count, removed_count, output ready);
endinterface

// File: rtl/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl: sequencer of the process table tracker
// Takes a request word, runs the table walk, commits and hands off the result.
// ----------------------------------------------------------------------------
module ptt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ptt_pkg::ptt_sts_t sts_i,
  output ptt_pkg::ptt_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StWalk   = 5'b00010,
    StFinish = 5'b00100,
    StMul    = 5'b01000,
    StOut    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = StWalk;
      StWalk:   if (sts_i.walk_done) state_d = StFinish;
      StFinish: state_d = StMul;
      StMul:    if (sts_i.fin_done) state_d = StOut;
      StOut:    if (out_ready_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = (state_q == StOut);
  assign cmd_o.start  = (state_q == StIdle) && in_valid_i;
  assign cmd_o.walk   = (state_q == StWalk);
  assign cmd_o.finish = (state_q == StFinish);

endmodule

// File: rtl/ptt_dp.sv
// ----------------------------------------------------------------------------
// ptt_dp: datapath of the process table tracker
// Entry memories, walk index, search registers, size and threshold arithmetic.
// ----------------------------------------------------------------------------
module ptt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptt_pkg::ptt_cmd_t             cmd_i,
  output ptt_pkg::ptt_sts_t             sts_o,
  input  logic [ptt_pkg::FuncW-1:0]     func_i,
  input  logic [ptt_pkg::IdW-1:0]       proc_id_i,
  input  logic [ptt_pkg::PagesW-1:0]    pages_i,
  input  logic [ptt_pkg::OomW-1:0]      oom_i,
  input  logic [ptt_pkg::PageBW-1:0]    page_bytes_i,
  input  logic [ptt_pkg::MemW-1:0]      total_mem_i,
  input  logic [ptt_pkg::ThrW-1:0]      threshold_i,
  output ptt_pkg::ptt_res_t             res_o
);

  localparam int unsigned IdxW = $clog2(ptt_pkg::TableDepth);
  localparam int unsigned CntW = IdxW + 1;

  // Entry stores; valid bits stand in for the cleared reset state
  logic [ptt_pkg::IdW-1:0]    id_mem   [ptt_pkg::TableDepth];
  logic [ptt_pkg::PagesW-1:0] pg_mem   [ptt_pkg::TableDepth];
  logic [ptt_pkg::PagesW-1:0] init_mem [ptt_pkg::TableDepth];
  logic [ptt_pkg::OomW-1:0]   oom_mem  [ptt_pkg::TableDepth];
  logic [ptt_pkg::GenW-1:0]   gen_mem  [ptt_pkg::TableDepth];
  logic [ptt_pkg::TableDepth-1:0] vld_q;

  logic [ptt_pkg::FuncW-1:0]  func_q;
  logic [ptt_pkg::IdW-1:0]    pid_q;
  logic [ptt_pkg::PagesW-1:0] pages_q;
  logic [ptt_pkg::OomW-1:0]   oom_q;

  logic [CntW-1:0]            fill_q, live_q, removed_q, idx_q;
  logic [ptt_pkg::GenW-1:0]   gen_q;
  logic                       hit_q, free_hit_q, any_q;
  logic [IdxW-1:0]            hit_idx_q, free_idx_q, best_idx_q;
  logic [ptt_pkg::PagesW-1:0] best_pg_q;
  logic [ptt_pkg::IdW-1:0]    best_id_q;
  logic [ptt_pkg::PagesW-1:0] hit_init_q;
  logic                       upd_ok_q;

  // Arithmetic for the finish steps
  logic [1:0]                 ph_q;
  logic [ptt_pkg::MemW+1:0]   raw_q;
  logic [ptt_pkg::MemW-1:0]   mem_q;
  logic [ptt_pkg::MemW+13:0]  lhs_q, rhs_q;

  // Committed action registered by finish
  ptt_pkg::ptt_res_t          res_q;
  ptt_pkg::ptt_res_t          res_fin;

  // Registered read of the walked entry (array read at one index)
  logic [IdxW-1:0]            widx;
  logic                       rd_en_q;
  logic [IdxW-1:0]            rd_idx_q;
  logic [ptt_pkg::IdW-1:0]    rd_id_q;
  logic [ptt_pkg::PagesW-1:0] rd_pg_q;
  logic [ptt_pkg::PagesW-1:0] rd_init_q;
  logic [ptt_pkg::GenW-1:0]   rd_gen_q;
  logic                       rd_vld_q;
  logic                       walk_end;

  assign widx     = idx_q[IdxW-1:0];
  assign walk_end = (idx_q >= fill_q);

  always_ff @(posedge clk_i) begin
    rd_id_q   <= id_mem[widx];
    rd_pg_q   <= pg_mem[widx];
    rd_init_q <= init_mem[widx];
    rd_gen_q  <= gen_mem[widx];
  end

  // Evaluate the entry read on the previous walk cycle
  logic rd_live;
  assign rd_live = rd_vld_q && (rd_id_q != '0);

  logic stop_early;
  assign stop_early = rd_en_q && rd_live && (rd_id_q == pid_q) &&
                      (func_q == ptt_pkg::FuncUpdate || func_q == ptt_pkg::FuncExpire);

  assign sts_o.walk_done = cmd_i.walk && (stop_early || hit_q ||
                           (walk_end && !rd_en_q) ||
                           (func_q != ptt_pkg::FuncUpdate && func_q != ptt_pkg::FuncExpire &&
                            func_q != ptt_pkg::FuncEnd && func_q != ptt_pkg::FuncKill) ||
                           (pid_q == '0 && func_q != ptt_pkg::FuncEnd &&
                            func_q != ptt_pkg::FuncKill));
  assign sts_o.fin_done  = (ph_q == 2'd3);

  // End-scan frees: computed on the evaluated entry
  logic sweep_free;
  assign sweep_free = rd_en_q && func_q == ptt_pkg::FuncEnd && rd_live &&
                      (rd_gen_q != gen_q);

  // Walk, search and request capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; rd_en_q <= 1'b0; hit_q <= 1'b0; free_hit_q <= 1'b0; any_q <= 1'b0;
      removed_q <= '0; rd_vld_q <= 1'b0; rd_idx_q <= '0;
      best_pg_q <= '0; best_idx_q <= '0; best_id_q <= '0;
      hit_idx_q <= '0; free_idx_q <= '0; hit_init_q <= '0;
    end else if (cmd_i.start) begin
      idx_q <= '0; rd_en_q <= 1'b0; hit_q <= 1'b0; free_hit_q <= 1'b0; any_q <= 1'b0;
      removed_q <= '0;
      best_pg_q <= '0; best_idx_q <= '0; best_id_q <= '0;
      hit_idx_q <= '0; free_idx_q <= '0; hit_init_q <= '0;
    end else if (cmd_i.walk) begin
      rd_en_q  <= !walk_end && !stop_early;
      rd_idx_q <= widx;
      rd_vld_q <= vld_q[widx];
      if (!walk_end) idx_q <= idx_q + CntW'(1);
      if (rd_en_q) begin
        if (stop_early) begin
          hit_q <= 1'b1; hit_idx_q <= rd_idx_q; hit_init_q <= rd_init_q;
        end
        if (!rd_live && !free_hit_q) begin
          free_hit_q <= 1'b1; free_idx_q <= rd_idx_q;
        end
        if (rd_live && rd_pg_q > best_pg_q) begin
          any_q <= 1'b1; best_pg_q <= rd_pg_q; best_idx_q <= rd_idx_q; best_id_q <= rd_id_q;
        end
        if (sweep_free) removed_q <= removed_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q <= func_i; pid_q <= proc_id_i; pages_q <= pages_i; oom_q <= oom_i;
    end
  end

  // Commit decision
  logic           upd_ok, new_slot, full;
  logic [IdxW-1:0] upd_slot;
  always_comb begin
    new_slot = !hit_q;
    full     = !hit_q && (fill_q >= CntW'(ptt_pkg::TableDepth)) && !free_hit_q;
    upd_ok   = func_q == ptt_pkg::FuncUpdate && pid_q != '0 && !full;
    if (hit_q)                                    upd_slot = hit_idx_q;
    else if (fill_q < CntW'(ptt_pkg::TableDepth)) upd_slot = fill_q[IdxW-1:0];
    else                                          upd_slot = free_idx_q;
  end

  // Table writes and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0; fill_q <= '0; live_q <= '0; gen_q <= '0; upd_ok_q <= 1'b0;
    end else begin
      if (cmd_i.walk && sweep_free) begin
        vld_q[rd_idx_q] <= 1'b0;
      end
      if (cmd_i.walk && sweep_free && rd_en_q) begin
        if (live_q != '0) live_q <= live_q - CntW'(1);
      end
      if (cmd_i.finish) begin
        upd_ok_q <= upd_ok;
        unique case (func_q)
          ptt_pkg::FuncUpdate: if (upd_ok) begin
            vld_q[upd_slot] <= 1'b1;
            if (new_slot) begin
              live_q <= live_q + CntW'(1);
              if (fill_q < CntW'(ptt_pkg::TableDepth)) fill_q <= fill_q + CntW'(1);
            end
          end
          ptt_pkg::FuncExpire: if (hit_q) begin
            vld_q[hit_idx_q] <= 1'b0;
            if (live_q != '0) live_q <= live_q - CntW'(1);
          end
          ptt_pkg::FuncBegin: gen_q <= gen_q + ptt_pkg::GenW'(1);
          ptt_pkg::FuncKill: if (any_q) begin
            vld_q[best_idx_q] <= 1'b0;
            if (live_q != '0) live_q <= live_q - CntW'(1);
          end
          default: ;
        endcase
      end
    end
  end

  // Entry payload memory writes; a claimed slot restarts its initial size
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && upd_ok) begin
      id_mem[upd_slot]  <= pid_q;
      pg_mem[upd_slot]  <= pages_q;
      oom_mem[upd_slot] <= oom_q;
      gen_mem[upd_slot] <= gen_q;
      if (new_slot || hit_init_q == '0)
        init_mem[upd_slot] <= pages_q;
    end
  end

  // Size and threshold: multiply, saturate, then cross-multiply compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ph_q <= '0;
    else if (cmd_i.finish) ph_q <= 2'd1;
    else if (ph_q != 2'd0 && ph_q != 2'd3) ph_q <= ph_q + 2'd1;
    else if (ph_q == 2'd3) ph_q <= 2'd0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish)
      raw_q <= (ptt_pkg::MemW+2)'(pages_q) * (ptt_pkg::MemW+2)'(page_bytes_i);
    if (ph_q == 2'd1) begin
      mem_q <= (raw_q > (ptt_pkg::MemW+2)'(ptt_pkg::Mem48Max)) ? ptt_pkg::Mem48Max
                                                               : raw_q[ptt_pkg::MemW-1:0];
    end
    if (ph_q == 2'd2) begin
      lhs_q <= (ptt_pkg::MemW+14)'(mem_q) * (ptt_pkg::MemW+14)'(14'd10000);
      rhs_q <= (ptt_pkg::MemW+14)'(threshold_i) * (ptt_pkg::MemW+14)'(total_mem_i);
    end
  end

  // Result word of the committed action
  always_comb begin
    res_fin = '0;
    unique case (func_q)
      ptt_pkg::FuncUpdate: begin
        if (pid_q == '0)  res_fin.status = ptt_pkg::StatusNotFound;
        else if (full)    res_fin.status = ptt_pkg::StatusFull;
        else              res_fin.slot   = ptt_pkg::SlotW'(upd_slot);
      end
      ptt_pkg::FuncExpire: begin
        if (hit_q) res_fin.slot   = ptt_pkg::SlotW'(hit_idx_q);
        else       res_fin.status = ptt_pkg::StatusNotFound;
      end
      ptt_pkg::FuncEnd: res_fin.removed_count = ptt_pkg::CountW'(removed_q);
      ptt_pkg::FuncKill: begin
        if (any_q) begin
          res_fin.slot      = ptt_pkg::SlotW'(best_idx_q);
          res_fin.target_id = best_id_q;
        end else res_fin.status = ptt_pkg::StatusNotFound;
      end
      default: ;
    endcase
  end

  // Result word built at finish, arithmetic fields filled when settled
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q <= res_fin;
    end else if (ph_q == 2'd3) begin
      res_q.live_count <= ptt_pkg::CountW'(live_q);
      if (upd_ok_q) begin
        res_q.memory_bytes <= mem_q;
        res_q.over_limit   <= (threshold_i != '0) && (lhs_q > rhs_q);
      end
    end
  end

  assign res_o = res_q;

endmodule

// File: rtl/process_table_tracker_unit.sv
// ----------------------------------------------------------------------------
// process_table_tracker_unit: keyed process table with generation aging
// A walk of the fill-mark entries (one per cycle, early exit on an update or expire
// match) is followed by the finish step and the size arithmetic; one word at a time.
// Reset clears valid bits, counters and the walk registers; the table reads as free.
// The result register holds until taken; the next word enters after that.
// ----------------------------------------------------------------------------
module process_table_tracker_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ptt_req_if.sink                          req,
  ptt_res_if.source                        res,
  input  logic                             cfg_we_i,
  input  logic [ptt_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ptt_pkg::MemW-1:0]         cfg_data_i
);

  ptt_pkg::ptt_cmd_t cmd;
  ptt_pkg::ptt_sts_t sts;
  ptt_pkg::ptt_res_t rword;

  logic [ptt_pkg::PageBW-1:0] page_bytes_q;
  logic [ptt_pkg::MemW-1:0]   total_mem_q;
  logic [ptt_pkg::ThrW-1:0]   threshold_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_bytes_q <= ptt_pkg::PageBW'(4096);
      total_mem_q  <= ptt_pkg::MemW'(1073741824);
      threshold_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ptt_pkg::CfgPageBytes) page_bytes_q <= cfg_data_i[ptt_pkg::PageBW-1:0];
      if (cfg_idx_i == ptt_pkg::CfgTotalMem)  total_mem_q  <= cfg_data_i;
      if (cfg_idx_i == ptt_pkg::CfgThreshold) threshold_q  <= cfg_data_i[ptt_pkg::ThrW-1:0];
    end
  end

  ptt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid), .in_ready_o (req.ready),
    .out_valid_o(res.valid), .out_ready_i(res.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  ptt_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .func_i(req.func), .proc_id_i(req.proc_id), .pages_i(req.resident_pages),
    .oom_i(req.oom_value), .page_bytes_i(page_bytes_q), .total_mem_i(total_mem_q),
    .threshold_i(threshold_q), .res_o(rword)
  );

  assign res.status        = rword.status;
  assign res.slot          = rword.slot;
  assign res.target_id     = rword.target_id;
  assign res.over_limit    = rword.over_limit;
  assign res.memory_bytes  = rword.memory_bytes;
  assign res.live_count    = rword.live_count;
  assign res.removed_count = rword.removed_count;

  // A word is never taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni) res.valid |-> !req.ready)
    else $error("input taken with result pending");
  // Accepting a word leads into the walk, not straight to a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !res.valid)
    else $error("result without walk");
  // Live count never exceeds the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (res.live_count <= ptt_pkg::CountW'(ptt_pkg::TableDepth)))
    else $error("live count overflow");

endmodule

// File: tb/sv/tb_process_table_tracker_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_process_table_tracker_unit: self-checking bench of the process tracker
// Queue-fed driver and checking monitor on the request and result channels.
// A shadow table predicts every result word. The register settings change
// between idle phases. Both channels stall at random, with one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_process_table_tracker_unit;

  localparam int unsigned Depth     = ptt_pkg::TableDepth;
  localparam int unsigned DrainWait = Depth + 40;

  typedef struct packed {
    logic [ptt_pkg::FuncW-1:0]  func;
    logic [ptt_pkg::IdW-1:0]    proc_id;
    logic [ptt_pkg::PagesW-1:0] pages;
    logic [ptt_pkg::OomW-1:0]   oom;
  } cmd_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ptt_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [ptt_pkg::MemW-1:0] cfg_data_i = '0;

  ptt_req_if req ();
  ptt_res_if res ();

  process_table_tracker_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req.sink),
    .res        (res.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow table and registers
  logic [ptt_pkg::IdW-1:0]    tbl_id    [Depth];
  logic [ptt_pkg::PagesW-1:0] tbl_pages [Depth];
  logic [ptt_pkg::GenW-1:0]   tbl_gen   [Depth];
  int unsigned       fill_cnt = 0;
  int unsigned       live_cnt = 0;
  logic [ptt_pkg::GenW-1:0]   scan_gen = '0;
  logic [63:0]       page_sz = 64'd4096;
  logic [63:0]       sys_mem = 64'd1073741824;
  logic [63:0]       thr_cp  = 64'd0;

  cmd_word_t          pending_words[$];
  ptt_pkg::ptt_res_t  expected_res[$];
  int                 errors = 0;

  initial begin
    for (int k = 0; k < Depth; k++) begin
      tbl_id[k] = '0;
      tbl_pages[k] = '0;
      tbl_gen[k] = '0;
    end
  end

  // Compute the result word of one command and update the shadow table
  task automatic track_cmd(input cmd_word_t w, output ptt_pkg::ptt_res_t r);
    int   s;
    bit   hit;
    logic [ptt_pkg::PagesW-1:0] top;
    logic [63:0] mem;
    r = '0;
    s = 0;
    hit = 0;
    case (w.func)
      ptt_pkg::FuncUpdate: begin
        if (w.proc_id == '0) begin
          r.status = ptt_pkg::StatusNotFound;
        end else begin
          for (int i = 0; i < fill_cnt; i++)
            if (!hit && tbl_id[i] == w.proc_id) begin
              s = i;
              hit = 1;
            end
          if (!hit) begin
            if (fill_cnt < Depth) begin
              s = fill_cnt;
              fill_cnt++;
              hit = 1;
            end else begin
              for (int i = 0; i < Depth; i++)
                if (!hit && tbl_id[i] == '0) begin
                  s = i;
                  hit = 1;
                end
            end
            if (hit) live_cnt++;
          end
          if (!hit) begin
            r.status = ptt_pkg::StatusFull;
          end else begin
            tbl_id[s] = w.proc_id;
            tbl_pages[s] = w.pages;
            tbl_gen[s] = scan_gen;
            mem = 64'(w.pages) * page_sz;
            if (mem > 64'(ptt_pkg::Mem48Max)) mem = 64'(ptt_pkg::Mem48Max);
            r.memory_bytes = mem[ptt_pkg::MemW-1:0];
            r.over_limit = (thr_cp != 0) && (mem * 64'd10000 > thr_cp * sys_mem);
            r.slot = s[ptt_pkg::SlotW-1:0];
          end
        end
      end
      ptt_pkg::FuncExpire: begin
        r.status = ptt_pkg::StatusNotFound;
        if (w.proc_id != '0)
          for (int i = 0; i < fill_cnt; i++)
            if (!hit && tbl_id[i] == w.proc_id) begin
              hit = 1;
              tbl_id[i] = '0;
              if (live_cnt > 0) live_cnt--;
              r.slot = i[ptt_pkg::SlotW-1:0];
              r.status = ptt_pkg::StatusOk;
            end
      end
      ptt_pkg::FuncBegin: scan_gen = scan_gen + 1'b1;
      ptt_pkg::FuncEnd: begin
        for (int i = 0; i < fill_cnt; i++)
          if (tbl_id[i] != '0 && tbl_gen[i] != scan_gen) begin
            tbl_id[i] = '0;
            if (live_cnt > 0) live_cnt--;
            r.removed_count = r.removed_count + 1'b1;
          end
      end
      ptt_pkg::FuncKill: begin
        top = '0;
        for (int i = 0; i < fill_cnt; i++)
          if (tbl_id[i] != '0 && tbl_pages[i] > top) begin
            top = tbl_pages[i];
            s = i;
            hit = 1;
          end
        if (hit) begin
          r.target_id = tbl_id[s];
          r.slot = s[ptt_pkg::SlotW-1:0];
          tbl_id[s] = '0;
          if (live_cnt > 0) live_cnt--;
        end else begin
          r.status = ptt_pkg::StatusNotFound;
        end
      end
      default: ;
    endcase
    r.live_count = live_cnt[ptt_pkg::CountW-1:0];
  endtask

  // Sender: bursts of words with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_word_t w;
    ptt_pkg::ptt_res_t r;
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.func <= '0;
      req.proc_id <= '0;
      req.resident_pages <= '0;
      req.oom_value <= '0;
    end else begin
      if (req.valid && req.ready) begin
        w = {req.func, req.proc_id, req.resident_pages, req.oom_value};
        track_cmd(w, r);
        expected_res.push_back(r);
      end
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          req.func <= w.func;
          req.proc_id <= w.proc_id;
          req.resident_pages <= w.pages;
          req.oom_value <= w.oom;
          req.valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Receiver: stall pattern, one long hold-off, and result checking
  int unsigned words_seen = 0;
  int unsigned hold_cnt = 0;
  bit          hold_done = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    ptt_pkg::ptt_res_t e;
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        words_seen++;
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result word, status %0d", $time, res.status);
          errors++;
        end else begin
          e = expected_res.pop_front();
          check_field("status", 64'(e.status), 64'(res.status));
          check_field("slot", 64'(e.slot), 64'(res.slot));
          check_field("target_id", 64'(e.target_id), 64'(res.target_id));
          check_field("over_limit", 64'(e.over_limit), 64'(res.over_limit));
          check_field("memory_bytes", 64'(e.memory_bytes), 64'(res.memory_bytes));
          check_field("live_count", 64'(e.live_count), 64'(res.live_count));
          check_field("removed_count", 64'(e.removed_count), 64'(res.removed_count));
        end
      end
      if (!hold_done && words_seen == 600) begin
        hold_done = 1;
        hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res.ready <= 1'b0;
      end else if ((words_seen / 64) % 2 == 0) begin
        res.ready <= 1'b1;
      end else begin
        res.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic write_reg(input logic [ptt_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[ptt_pkg::MemW-1:0];
    case (idx)
      ptt_pkg::CfgPageBytes: page_sz = val & 64'h1FFFF;
      ptt_pkg::CfgTotalMem:  sys_mem = val & 64'(ptt_pkg::Mem48Max);
      ptt_pkg::CfgThreshold: thr_cp = val & 64'h3FFF;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [63:0] pb, input logic [63:0] tm,
                          input logic [63:0] th);
    write_reg(ptt_pkg::CfgPageBytes, pb);
    write_reg(ptt_pkg::CfgTotalMem, tm);
    write_reg(ptt_pkg::CfgThreshold, th);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && expected_res.size() == 0 && !req.valid);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic push_word(input logic [ptt_pkg::FuncW-1:0] f,
                           input logic [ptt_pkg::IdW-1:0] id,
                           input logic [ptt_pkg::PagesW-1:0] pg,
                           input logic [ptt_pkg::OomW-1:0] oom);
    pending_words.push_back({f, id, pg, oom});
  endtask

  function automatic logic [ptt_pkg::PagesW-1:0] rand_pages();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(1, 5000);
    endcase
  endfunction

  // Mostly updates on a small id pool so lookups hit; expires, scans, kills and unused codes mixed in
  task automatic push_random(input int n);
    int unsigned pick;
    logic [ptt_pkg::FuncW-1:0] f;
    logic [ptt_pkg::IdW-1:0] id;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) f = ptt_pkg::FuncUpdate;
      else if (pick < 74) f = ptt_pkg::FuncExpire;
      else if (pick < 81) f = ptt_pkg::FuncBegin;
      else if (pick < 88) f = ptt_pkg::FuncEnd;
      else if (pick < 98) f = ptt_pkg::FuncKill;
      else f = ptt_pkg::FuncKill + 3'($urandom_range(1, 3));
      pick = $urandom_range(0, 99);
      if (pick < 3) id = '0;
      else if (pick < 8) id = 22'($urandom());
      else id = 22'($urandom_range(1, 320));
      push_word(f, id, rand_pages(), 11'($urandom_range(0, 2000)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset settings, empty table cases, extremes, every function
    push_word(ptt_pkg::FuncKill, '0, '0, '0);
    push_word(ptt_pkg::FuncExpire, 22'd5, '0, '0);
    push_word(ptt_pkg::FuncEnd, '0, '0, '0);
    push_word(ptt_pkg::FuncUpdate, '0, 32'd10, 11'd3);
    push_word(ptt_pkg::FuncExpire, '0, '0, '0);
    push_word(ptt_pkg::FuncUpdate, 22'h3FFFFF, 32'hFFFF_FFFF, 11'd2000);
    push_word(ptt_pkg::FuncUpdate, 22'd1, '0, '0);
    push_word(ptt_pkg::FuncUpdate, 22'd1, 32'd77, 11'd1023);
    push_word(ptt_pkg::FuncUpdate, 22'd2, 32'd77, 11'd1);
    push_word(ptt_pkg::FuncUpdate, 22'd3, 32'd0, 11'd0);
    push_word(ptt_pkg::FuncKill, '0, '0, '0);
    push_word(ptt_pkg::FuncBegin, '0, '0, '0);
    push_word(ptt_pkg::FuncUpdate, 22'd2, 32'd5, 11'd5);
    push_word(ptt_pkg::FuncEnd, '0, '0, '0);
    push_word(ptt_pkg::FuncExpire, 22'd2, '0, '0);
    push_word(ptt_pkg::FuncExpire, 22'd2, '0, '0);
    push_word(3'd5, 22'd9, 32'd9, 11'd9);
    push_word(3'd7, 22'h2AAAAA, 32'h5555_5555, 11'h555);
    push_word(ptt_pkg::FuncUpdate, 22'd3, 32'd0, 11'd0);
    push_word(ptt_pkg::FuncKill, '0, '0, '0);
    // generation wrap back to a stamp still in the table
    for (int k = 0; k < 4; k++) push_word(ptt_pkg::FuncBegin, '0, '0, '0);
    drain();
    for (int k = 0; k < 252; k++) push_word(ptt_pkg::FuncBegin, '0, '0, '0);
    push_word(ptt_pkg::FuncEnd, '0, '0, '0);
    drain();

    // Smallest settings: fill the table, overflow it, then reuse a freed slot
    set_regs(64'd1, 64'd1, 64'd1);
    for (int k = 0; k < Depth; k++)
      push_word(ptt_pkg::FuncUpdate, 22'(1000 + k), $urandom_range(0, 3),
                11'($urandom_range(0, 2000)));
    push_word(ptt_pkg::FuncUpdate, 22'd5000, 32'd4, 11'd4);
    push_word(ptt_pkg::FuncExpire, 22'd1100, '0, '0);
    push_word(ptt_pkg::FuncUpdate, 22'd5000, 32'd8, 11'd4);
    push_word(ptt_pkg::FuncKill, '0, '0, '0);
    push_random(200);
    drain();

    // Large settings: byte counts near the 48-bit limit against a threshold of 10000
    set_regs(64'd65536, 64'(ptt_pkg::Mem48Max), 64'd10000);
    push_word(ptt_pkg::FuncUpdate, 22'd7, 32'hFFFF_FFFF, 11'd2000);
    push_random(300);
    drain();

    set_regs($urandom_range(1, 65536), {$urandom_range(0, 65535), 32'($urandom())} | 64'd1,
             $urandom_range(0, 10000));
    push_random(400);
    drain();

    set_regs(64'd4096, 64'd1 << 30, 64'd5000);
    push_random(400);
    drain();

    set_regs(64'd512, 64'd1 << 20, 64'd0);
    push_random(200);
    drain();

    if (errors == 0) begin
      $display("tb_process_table_tracker_unit passed");
    end else begin
      $display("tb_process_table_tracker_unit failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("tb_process_table_tracker_unit failed");
    $finish;
  end

endmodule
